// ===== sv/faa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_pkg
// Shared types and constants of the fragment angle energy unit.
// ----------------------------------------------------------------------------
package faa_pkg;

    // table depth default, angle constants in Q3.12 radians
    localparam int FRAG_TYPES_DEFAULT = 256;
    localparam int PI_Q12             = 12868;
    localparam int TWO_PI_Q12         = 25736;

    // front to back queue depth
    localparam int QUEUE_DEPTH = 2;

    // one table row holds six 16-bit parameters
    localparam int NUM_PARAMS = 6;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    typedef enum logic [2:0] {
        SEL_TAU0  = 3'd0,
        SEL_TAUK  = 3'd1,
        SEL_OM1_0 = 3'd2,
        SEL_OM1_K = 3'd3,
        SEL_OM2_0 = 3'd4,
        SEL_OM2_K = 3'd5
    } t_param_sel;

    typedef enum logic [2:0] {
        POS_MIDDLE = 3'd0,
        POS_NTERM  = 3'd1,
        POS_CTERM  = 3'd2,
        POS_NCTERM = 3'd3,
        POS_OTHER  = 3'd4
    } t_position;

    // omega weight on the Q.33 scale: half term 1, full term 2
    typedef enum logic [1:0] {
        W_NONE = 2'd0,
        W_HALF = 2'd1,
        W_FULL = 2'd2
    } t_weight;

    // classified item as it sits in the queue
    typedef struct packed {
        logic               is_score;
        logic               load_we;   // load that really writes the table
        logic               type_ok;   // frag_type inside the table
        logic [7:0]         frag_type;
        logic [2:0]         param_sel;
        logic signed [15:0] param_value;
        logic signed [15:0] tau_angle;
        logic signed [15:0] omega1_angle;
        logic signed [15:0] omega2_angle;
        t_weight            w1;
        t_weight            w2;
        logic               last_fragment;
    } t_queue_item;

    typedef struct packed {
        logic        valid;
        t_queue_item item;
    } t_queue_out;

    typedef struct packed {
        logic pop;
        logic clearing;
    } t_back_ctl;

endpackage

// ===== sv/faa_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface faa_in_if;
    logic               valid;
    logic               ready;
    logic               command;
    logic [7:0]         frag_type;
    logic [2:0]         param_select;
    logic signed [15:0] param_value;
    logic signed [15:0] tau_angle;
    logic signed [15:0] omega1_angle;
    logic signed [15:0] omega2_angle;
    logic [2:0]         position;
    logic               last_fragment;

    modport source (
        output valid, command, frag_type, param_select, param_value,
               tau_angle, omega1_angle, omega2_angle, position, last_fragment,
        input  ready
    );
    modport sink (
        input  valid, command, frag_type, param_select, param_value,
               tau_angle, omega1_angle, omega2_angle, position, last_fragment,
        output ready
    );
endinterface

interface faa_out_if;
    logic        valid;
    logic        ready;
    logic [39:0] frag_score;
    logic [47:0] run_total;
    logic        total_final;

    modport source (
        output valid, frag_score, run_total, total_final,
        input  ready
    );
    modport sink (
        input  valid, frag_score, run_total, total_final,
        output ready
    );
endinterface

// ===== sv/faa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module faa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/faa_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_front
// Accepts items, classifies them and buffers them in a short queue.
// ----------------------------------------------------------------------------
module faa_front
    import faa_pkg::*;
#(
    parameter int NUM_FRAG_TYPES = FRAG_TYPES_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    faa_in_if.sink     i_in,
    input  t_back_ctl  i_ctl,
    output t_queue_out o_q
);

    localparam int AW  = (NUM_FRAG_TYPES > 1) ? $clog2(NUM_FRAG_TYPES) : 1;
    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    t_queue_item      r_q [QUEUE_DEPTH];
    logic [QAW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0]   r_count,  n_count;

    t_queue_item      cls;
    logic [AW+7:0]    type_ext;
    logic             push;
    logic             pop;

    // classification
    always_comb begin
        type_ext          = {{AW{1'b0}}, i_in.frag_type};
        cls.is_score      = (i_in.command == CMD_SCORE);
        cls.type_ok       = (type_ext < (AW + 8)'(NUM_FRAG_TYPES));
        cls.load_we       = (i_in.command == CMD_LOAD) && cls.type_ok
                            && (i_in.param_select < 3'(NUM_PARAMS));
        cls.frag_type     = i_in.frag_type;
        cls.param_sel     = i_in.param_select;
        cls.param_value   = i_in.param_value;
        cls.tau_angle     = i_in.tau_angle;
        cls.omega1_angle  = i_in.omega1_angle;
        cls.omega2_angle  = i_in.omega2_angle;
        cls.last_fragment = i_in.last_fragment;
        case (t_position'(i_in.position))
            POS_MIDDLE: begin cls.w1 = W_HALF; cls.w2 = W_HALF; end
            POS_NTERM:  begin cls.w1 = W_FULL; cls.w2 = W_HALF; end
            POS_CTERM:  begin cls.w1 = W_HALF; cls.w2 = W_FULL; end
            POS_NCTERM: begin cls.w1 = W_HALF; cls.w2 = W_HALF; end
            default:    begin cls.w1 = W_NONE; cls.w2 = W_NONE; end
        endcase
    end

    assign i_in.ready = !i_ctl.clearing && (r_count != QCW'(QUEUE_DEPTH));
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_ctl.pop;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({push, pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (push) begin
            r_q[r_wr_ptr] <= cls;
        end
    end

    assign o_q.valid = (r_count != '0);
    assign o_q.item  = r_q[r_rd_ptr];

endmodule

// ===== sv/faa_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_back
// Parameter table, energy pipeline and running total.
// ----------------------------------------------------------------------------
module faa_back
    import faa_pkg::*;
#(
    parameter int NUM_FRAG_TYPES = FRAG_TYPES_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_queue_out i_q,
    output t_back_ctl  o_ctl,
    faa_out_if.source  o_out
);

    localparam int AW = (NUM_FRAG_TYPES > 1) ? $clog2(NUM_FRAG_TYPES) : 1;
    localparam logic signed [17:0] L_PI     = 18'(PI_Q12);
    localparam logic signed [17:0] L_TWO_PI = 18'(TWO_PI_Q12);
    localparam logic [47:0]        TOTAL_MAX = '1;

    // table clear after reset
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    logic          advance;
    logic          pop;
    t_queue_item   qi;
    logic [AW+7:0] type_ext;
    logic [AW-1:0] tbl_addr;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic          rd_en;
    logic [NUM_PARAMS-1:0] we;
    logic [15:0]   rd [NUM_PARAMS];

    // stage 1: table data arrives
    logic               r_s1_valid;
    t_queue_item        r_s1;
    // stage 2: differences
    logic               r_s2_valid;
    logic signed [17:0] r_s2_dtau;
    logic signed [16:0] r_s2_d1, r_s2_d2;
    logic signed [15:0] r_s2_kt, r_s2_k1, r_s2_k2;
    t_weight            r_s2_w1, r_s2_w2;
    logic               r_s2_last;
    // stage 3: squares
    logic               r_s3_valid;
    logic [31:0]        r_s3_qt, r_s3_q1, r_s3_q2;
    logic signed [15:0] r_s3_kt, r_s3_k1, r_s3_k2;
    t_weight            r_s3_w1, r_s3_w2;
    logic               r_s3_last;
    // stage 4: terms, Q.32
    logic               r_s4_valid;
    logic signed [47:0] r_s4_tt, r_s4_t1, r_s4_t2;
    t_weight            r_s4_w1, r_s4_w2;
    logic               r_s4_last;
    // stage 5: fragment energy
    logic               r_s5_valid;
    logic [39:0]        r_s5_frag;
    logic               r_s5_last;
    // output and total
    logic               r_out_valid;
    logic [39:0]        r_out_frag;
    logic [47:0]        r_out_total;
    logic               r_out_final;
    logic [47:0]        r_sum;

    // combinational values per stage
    logic signed [15:0] p [NUM_PARAMS];
    logic signed [16:0] dtau_raw;
    logic signed [17:0] dtau;
    logic signed [16:0] d1, d2;
    logic signed [35:0] sq_t;
    logic signed [33:0] sq_1, sq_2;
    logic signed [48:0] m_t, m_1, m_2;
    logic signed [50:0] a_t, a_1, a_2, sum33;
    logic [39:0]        frag;
    logic [48:0]        total_raw;
    logic [47:0]        total;

    assign advance = !r_out_valid || o_out.ready;
    assign pop     = advance && !r_clearing && i_q.valid;
    assign qi      = i_q.item;

    assign type_ext = {{AW{1'b0}}, qi.frag_type};
    assign tbl_addr = type_ext[AW-1:0];
    assign wr_addr  = r_clearing ? r_clr_addr : tbl_addr;
    assign wr_data  = r_clearing ? 16'd0 : qi.param_value;
    assign rd_en    = pop && qi.is_score;

    for (genvar k = 0; k < NUM_PARAMS; k++) begin : g_tbl
        assign we[k] = r_clearing
                       || (pop && qi.load_we && (qi.param_sel == 3'(k)));
        faa_ram #(
            .WIDTH (16),
            .DEPTH (NUM_FRAG_TYPES)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[k]),
            .i_waddr (wr_addr),
            .i_wdata (wr_data),
            .i_re    (rd_en),
            .i_raddr (tbl_addr),
            .o_rdata (rd[k])
        );
        // type beyond the table scores with zero parameters
        assign p[k] = r_s1.type_ok ? $signed(rd[k]) : 16'sd0;
    end

    assign o_ctl.pop      = pop;
    assign o_ctl.clearing = r_clearing;

    // stage 1 -> 2: differences, single wrap of tau
    always_comb begin
        dtau_raw = 17'(p[SEL_TAU0]) - 17'(r_s1.tau_angle);
        dtau     = 18'(dtau_raw);
        if ((dtau >= L_PI) || (dtau <= -L_PI)) begin
            dtau = (dtau > 18'sd0) ? dtau - L_TWO_PI : dtau + L_TWO_PI;
        end
        d1 = 17'(r_s1.omega1_angle) - 17'(p[SEL_OM1_0]);
        d2 = 17'(r_s1.omega2_angle) - 17'(p[SEL_OM2_0]);
    end

    // stage 2 -> 3: squares, all nonnegative and below 2^32
    always_comb begin
        sq_t = r_s2_dtau * r_s2_dtau;
        sq_1 = r_s2_d1 * r_s2_d1;
        sq_2 = r_s2_d2 * r_s2_d2;
    end

    // stage 3 -> 4: stiffness times square
    always_comb begin
        m_t = $signed({1'b0, r_s3_qt}) * r_s3_kt;
        m_1 = $signed({1'b0, r_s3_q1}) * r_s3_k1;
        m_2 = $signed({1'b0, r_s3_q2}) * r_s3_k2;
    end

    // stage 4 -> 5: weighted sum in Q.33, clamp, drop to 16 fractional bits
    always_comb begin
        a_t = 51'(r_s4_tt) <<< 1;
        case (r_s4_w1)
            W_FULL:  a_1 = 51'(r_s4_t1) <<< 1;
            W_HALF:  a_1 = 51'(r_s4_t1);
            default: a_1 = '0;
        endcase
        case (r_s4_w2)
            W_FULL:  a_2 = 51'(r_s4_t2) <<< 1;
            W_HALF:  a_2 = 51'(r_s4_t2);
            default: a_2 = '0;
        endcase
        sum33 = a_t + a_1 + a_2;
        // the shifted sum stays below 2^34, well inside 40 bits
        frag  = (sum33 > 51'sd0) ? 40'(sum33[50:17]) : 40'd0;
    end

    // stage 5 -> out: saturating total
    always_comb begin
        total_raw = {1'b0, r_sum} + 49'(r_s5_frag);
        total     = total_raw[48] ? TOTAL_MAX : total_raw[47:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_sum       <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == AW'(NUM_FRAG_TYPES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end
            if (advance) begin
                r_s1_valid  <= rd_en;
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_s4_valid  <= r_s3_valid;
                r_s5_valid  <= r_s4_valid;
                r_out_valid <= r_s5_valid;
                if (r_s5_valid) begin
                    r_sum <= r_s5_last ? 48'd0 : total;
                end
            end
        end
        if (advance) begin
            if (rd_en) begin
                r_s1 <= qi;
            end
            r_s2_dtau   <= dtau;
            r_s2_d1     <= d1;
            r_s2_d2     <= d2;
            r_s2_kt     <= p[SEL_TAUK];
            r_s2_k1     <= p[SEL_OM1_K];
            r_s2_k2     <= p[SEL_OM2_K];
            r_s2_w1     <= r_s1.w1;
            r_s2_w2     <= r_s1.w2;
            r_s2_last   <= r_s1.last_fragment;
            r_s3_qt     <= sq_t[31:0];
            r_s3_q1     <= sq_1[31:0];
            r_s3_q2     <= sq_2[31:0];
            r_s3_kt     <= r_s2_kt;
            r_s3_k1     <= r_s2_k1;
            r_s3_k2     <= r_s2_k2;
            r_s3_w1     <= r_s2_w1;
            r_s3_w2     <= r_s2_w2;
            r_s3_last   <= r_s2_last;
            r_s4_tt     <= m_t[47:0];
            r_s4_t1     <= m_1[47:0];
            r_s4_t2     <= m_2[47:0];
            r_s4_w1     <= r_s3_w1;
            r_s4_w2     <= r_s3_w2;
            r_s4_last   <= r_s3_last;
            r_s5_frag   <= frag;
            r_s5_last   <= r_s4_last;
            r_out_frag  <= r_s5_frag;
            r_out_total <= total;
            r_out_final <= r_s5_last;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.frag_score  = r_out_frag;
    assign o_out.run_total   = r_out_total;
    assign o_out.total_final = r_out_final;

    // nothing leaves the queue while the table is being cleared
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !pop)
        else $error("queue popped during table clear");

    // a table read and a table write never come from the same item
    a_rd_wr_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(rd_en && (we != '0)))
        else $error("table read and write in one cycle");

    // a load writes at most one parameter of a row
    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_clearing |-> $onehot0(we))
        else $error("more than one parameter written by a load");

    // the running sum restarts after the last fragment of a pose
    a_sum_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s5_valid && r_s5_last) |=> (r_sum == 48'd0))
        else $error("running sum not cleared after last fragment");

    // a total always includes its own fragment
    a_total_ge_frag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_total >= 48'(r_out_frag)))
        else $error("total below fragment energy");

endmodule

// ===== sv/fragment_angle_energy_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fragment_angle_energy_unit
// Harmonic tau/omega angle energy of four-residue fragments, with a
// per-type parameter table and a saturating running pose total.
// ----------------------------------------------------------------------------
//
//  channel  dir  payload                                          moves
//  -------  ---  -----------------------------------------------  ---------
//  i_in     in   command, frag_type, param_select, param_value,   one item
//                tau/omega1/omega2 angle, position, last_fragment
//  o_out    out  frag_score, run_total, total_final               one item
//                (one per score item, none per load item)
//
//  Rate: one item per cycle sustained while o_out takes its items and
//  no table clear runs. A score item passes the table read, difference,
//  square, stiffness multiply, weighted sum and total add registers on
//  its way from the queue to o_out; the total add is the only loop.
//  Reset: after i_rst_n releases, the table is zeroed one row per cycle,
//  with i_in.ready low throughout.
//  Stalls: a two-item queue parts input from the pipeline; when o_out holds
//  an untaken item the whole pipeline freezes and the queue fills.
//
module fragment_angle_energy_unit
    import faa_pkg::*;
#(
    parameter int NUM_FRAG_TYPES = FRAG_TYPES_DEFAULT
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    faa_in_if.sink    i_in,
    faa_out_if.source o_out
);

    // queue head toward the back end, pop and clear status toward the front
    t_queue_out q;
    t_back_ctl  ctl;

    // front end: classify load/score, range-check the type, decode the
    // position into omega weights, and queue the item
    faa_front #(
        .NUM_FRAG_TYPES (NUM_FRAG_TYPES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_ctl   (ctl),
        .o_q     (q)
    );

    // back end: table writes for loads, energy pipeline for scores,
    // running total and output register
    faa_back #(
        .NUM_FRAG_TYPES (NUM_FRAG_TYPES)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (q),
        .o_ctl   (ctl),
        .o_out   (o_out)
    );

endmodule

// ===== verif/faa_energy_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// faa_energy_checker
// Watches both channels of the fragment angle energy unit, keeps its own
// parameter table and pose total, and compares every result item.
// ----------------------------------------------------------------------------
module faa_energy_checker
    import faa_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    faa_in_if         i_in_ch,
    faa_out_if        i_out_ch,
    output int        o_fail_count,
    output int        o_pending
);

    localparam logic [39:0] FRAG_LIMIT = '1;

    typedef struct {
        logic [39:0] frag;
        logic [47:0] total;
        logic        is_last;
    } t_energy_result;

    logic signed [15:0] param_rows [FRAG_TYPES_DEFAULT][NUM_PARAMS];
    logic [47:0]        pose_sum;
    t_energy_result     expected_results [$];

    // energy of one fragment plus the running total it leads to
    function automatic t_energy_result calc_fragment_energy(
        input logic [7:0]         ftype,
        input logic signed [15:0] tau,
        input logic signed [15:0] om1,
        input logic signed [15:0] om2,
        input logic [2:0]         pos,
        input logic               last
    );
        logic signed [15:0] p [NUM_PARAMS];
        int                 d_tau, d_om1, d_om2;
        longint             e_tau, e_om1, e_om2, sum33, scaled;
        t_weight            w_om1, w_om2;
        logic [48:0]        total;
        t_energy_result     r;
        // 8-bit type never leaves a 256-row table
        for (int i = 0; i < NUM_PARAMS; i++) p[i] = param_rows[ftype][i];

        // single wrap only; may stay outside +-pi
        d_tau = int'(p[SEL_TAU0]) - int'(tau);
        if (d_tau >= PI_Q12 || d_tau <= -PI_Q12)
            d_tau = (d_tau > 0) ? d_tau - TWO_PI_Q12 : d_tau + TWO_PI_Q12;
        d_om1 = int'(om1) - int'(p[SEL_OM1_0]);
        d_om2 = int'(om2) - int'(p[SEL_OM2_0]);

        e_tau = longint'(d_tau) * longint'(d_tau) * longint'(p[SEL_TAUK]);
        e_om1 = longint'(d_om1) * longint'(d_om1) * longint'(p[SEL_OM1_K]);
        e_om2 = longint'(d_om2) * longint'(d_om2) * longint'(p[SEL_OM2_K]);

        w_om1 = W_NONE;
        w_om2 = W_NONE;
        case (pos)
            POS_MIDDLE, POS_NCTERM: begin
                w_om1 = W_HALF;
                w_om2 = W_HALF;
            end
            POS_NTERM: begin
                w_om1 = W_FULL;
                w_om2 = W_HALF;
            end
            POS_CTERM: begin
                w_om1 = W_HALF;
                w_om2 = W_FULL;
            end
            default: ;
        endcase

        // Q.33 sum: tau always carries full weight
        sum33 = longint'(W_FULL) * e_tau + longint'(w_om1) * e_om1
              + longint'(w_om2) * e_om2;
        r.frag = '0;
        if (sum33 > 0) begin
            scaled = sum33 >>> 17;
            r.frag = (scaled > longint'(FRAG_LIMIT)) ? FRAG_LIMIT : scaled[39:0];
        end
        total     = {1'b0, pose_sum} + {9'd0, r.frag};
        r.total   = total[48] ? '1 : total[47:0];
        r.is_last = last;
        return r;
    endfunction

    always @(posedge i_clk) begin : track
        t_energy_result want;
        if (!i_rst_n) begin
            foreach (param_rows[t, s]) param_rows[t][s] = '0;
            pose_sum = '0;
            expected_results.delete();
        end else begin
            if (i_in_ch.valid && i_in_ch.ready) begin
                if (i_in_ch.command == CMD_LOAD) begin
                    // unused selects fall through
                    if (i_in_ch.param_select < NUM_PARAMS)
                        param_rows[i_in_ch.frag_type][i_in_ch.param_select] =
                            i_in_ch.param_value;
                end else begin
                    want = calc_fragment_energy(i_in_ch.frag_type, i_in_ch.tau_angle,
                                                i_in_ch.omega1_angle,
                                                i_in_ch.omega2_angle,
                                                i_in_ch.position,
                                                i_in_ch.last_fragment);
                    pose_sum = want.is_last ? '0 : want.total;
                    expected_results.insert(expected_results.size(), want);
                end
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result item: frag_score %0d run_total %0d",
                           i_out_ch.frag_score, i_out_ch.run_total);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_out_ch.frag_score !== want.frag) begin
                        $error("frag_score: expected %0d, actual %0d",
                               want.frag, i_out_ch.frag_score);
                        o_fail_count++;
                    end
                    if (i_out_ch.run_total !== want.total) begin
                        $error("run_total: expected %0d, actual %0d",
                               want.total, i_out_ch.run_total);
                        o_fail_count++;
                    end
                    if (i_out_ch.total_final !== want.is_last) begin
                        $error("total_final: expected %0d, actual %0d",
                               want.is_last, i_out_ch.total_final);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives load and score items into the fragment angle energy unit with
// random idle bursts on both channels; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb
    import faa_pkg::*;
();

    localparam int RANDOM_ITEMS   = 550;
    localparam int QUIET_TAIL     = 150;   // last items run without idling
    localparam int WATCHDOG_LIMIT = 2000;  // covers the table clear
    localparam int DRAIN_CYCLES   = 20;

    logic i_clk;
    logic i_rst_n;
    bit   bursts_on;
    int   fail_count;
    int   pending;

    faa_in_if  in_ch ();
    faa_out_if out_ch ();

    fragment_angle_energy_unit #(
        .NUM_FRAG_TYPES (FRAG_TYPES_DEFAULT)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    faa_energy_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // result side back-pressure
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (bursts_on && $urandom_range(0, 5) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17) - 1) @(negedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ends the run once nothing moves for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: errors");
        $finish;
    end

    // presents one item from a falling edge and holds it until taken
    task automatic drive_item(
        input logic               cmd,
        input logic [7:0]         ftype,
        input logic [2:0]         sel,
        input logic signed [15:0] value,
        input logic signed [15:0] tau,
        input logic signed [15:0] om1,
        input logic signed [15:0] om2,
        input logic [2:0]         pos,
        input logic               last
    );
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.command       <= cmd;
        in_ch.frag_type     <= ftype;
        in_ch.param_select  <= sel;
        in_ch.param_value   <= value;
        in_ch.tau_angle     <= tau;
        in_ch.omega1_angle  <= om1;
        in_ch.omega2_angle  <= om2;
        in_ch.position      <= pos;
        in_ch.last_fragment <= last;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        @(negedge i_clk);
    endtask

    // angle and position fields of a load are noise
    task automatic load_param(input logic [7:0] ftype, input logic [2:0] sel,
                              input logic signed [15:0] value);
        drive_item(CMD_LOAD, ftype, sel, value, 16'($urandom), 16'($urandom),
                   16'($urandom), 3'($urandom), 1'($urandom));
    endtask

    task automatic score_frag(input logic [7:0] ftype, input logic signed [15:0] tau,
                              input logic signed [15:0] om1,
                              input logic signed [15:0] om2,
                              input logic [2:0] pos, input logic last);
        drive_item(CMD_SCORE, ftype, 3'($urandom), 16'($urandom), tau, om1, om2,
                   pos, last);
    endtask

    // sender holds off until every score item has come back
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // mostly a handful of rows so scores hit loaded parameters
    function automatic logic [7:0] pick_type();
        return ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 11));
    endfunction

    function automatic logic signed [15:0] pick_angle();
        return ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8192) - 4096)
                                           : 16'($urandom);
    endfunction

    initial begin
        i_rst_n             = 1'b0;
        bursts_on           = 1'b0;
        in_ch.valid         = 1'b0;
        in_ch.command       = CMD_LOAD;
        in_ch.frag_type     = '0;
        in_ch.param_select  = SEL_TAU0;
        in_ch.param_value   = '0;
        in_ch.tau_angle     = '0;
        in_ch.omega1_angle  = '0;
        in_ch.omega2_angle  = '0;
        in_ch.position      = POS_MIDDLE;
        in_ch.last_fragment = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: unloaded row, full row at extremes, every position,
        // wrap at exactly +-pi and beyond, ignored selects, negative sum
        bursts_on = 1'b1;
        score_frag(8'd0, 16'sd1000, -16'sd1000, 16'sd0, POS_MIDDLE, 1'b0);
        load_param(8'd5, SEL_TAU0, 16'sd12000);
        load_param(8'd5, SEL_TAUK, 16'sh7FFF);
        load_param(8'd5, SEL_OM1_0, 16'sh8000);
        load_param(8'd5, SEL_OM1_K, 16'sd256);
        load_param(8'd5, SEL_OM2_0, 16'sh7FFF);
        load_param(8'd5, SEL_OM2_K, 16'sh8000);
        score_frag(8'd5, 16'sh8000, 16'sh7FFF, 16'sh8000, POS_NTERM, 1'b0);
        score_frag(8'd5, 16'sh7FFF, 16'sh8000, 16'sh7FFF, POS_CTERM, 1'b0);
        score_frag(8'd5, 16'sd12000, 16'sd0, 16'sd0, POS_NCTERM, 1'b0);
        score_frag(8'd5, 16'sd0, 16'sd100, -16'sd100, POS_OTHER, 1'b0);
        score_frag(8'd5, -16'sd868, 16'sd0, 16'sd0, 3'd7, 1'b0);
        load_param(8'd5, 3'd6, 16'sd1234);
        load_param(8'd5, 3'd7, -16'sd1234);
        score_frag(8'd5, 16'sd24868, 16'sh8000, 16'sh8000, POS_CTERM, 1'b1);
        load_param(8'd255, SEL_TAUK, 16'sd128);
        load_param(8'd255, SEL_TAU0, -16'sd12868);
        score_frag(8'd255, 16'sd0, 16'sh7FFF, 16'sh8000, POS_MIDDLE, 1'b1);
        score_frag(8'd0, 16'sh8000, 16'sh8000, 16'sh7FFF, POS_NTERM, 1'b0);
        score_frag(8'd5, 16'sd3000, -16'sd3000, 16'sd3000, POS_MIDDLE, 1'b1);
        wait_drained();

        // random: loads mixed into pose-long runs of scores
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            bursts_on = (n < RANDOM_ITEMS - QUIET_TAIL) && ((n / 60) % 3 != 2);
            if (n == 200 || n == 330)
                wait_drained();
            if ($urandom_range(0, 9) < 3)
                load_param(pick_type(),
                           ($urandom_range(0, 15) == 0) ? 3'($urandom_range(6, 7))
                                                        : 3'($urandom_range(0, 5)),
                           16'($urandom));
            else
                score_frag(pick_type(), pick_angle(), pick_angle(), pick_angle(),
                           ($urandom_range(0, 9) == 0) ? 3'($urandom_range(4, 7))
                                                       : 3'($urandom_range(0, 3)),
                           ($urandom_range(0, 7) == 0));
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
